// ===== hdl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharMul   = 8'h2A;
  localparam logic [7:0] CharDiv   = 8'h2F;
  localparam logic [7:0] CharPow   = 8'h5E;
  localparam logic [7:0] CharMod   = 8'h25;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_DIGIT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW, OP_BAD
  } op_e;

  // classified request passed from front to back
  typedef struct packed {
    op_e        op;
    logic [3:0] digit;
    logic       last;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EXEC, S_DIV, S_POW, S_WRITE, S_RESULT
  } state_e;

endpackage

// ===== hdl/pse_front.sv =====
// ----------------------------------------------------------------------------
// pse_front
// Classifies characters and queues them for the execution back end.
// ----------------------------------------------------------------------------
module pse_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [7:0]    symbol_i,
  input  logic          last_i,
  output logic          req_valid_o,
  input  logic          req_take_i,
  output pse_pkg::req_t req_o
);
  import pse_pkg::*;

  req_t       fifo_q [QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  req_t       cls;
  logic       wr_en, rd_en;

  // character decode
  always_comb begin
    cls.digit = 4'd0;
    cls.last  = last_i;
    cls.op    = OP_BAD;
    if (symbol_i inside {[CharZero:CharNine]}) begin
      cls.op    = OP_DIGIT;
      cls.digit = 4'(symbol_i - CharZero);
    end else begin
      case (symbol_i)
        CharPlus:  cls.op = OP_ADD;
        CharMinus: cls.op = OP_SUB;
        CharMul:   cls.op = OP_MUL;
        CharDiv:   cls.op = OP_DIV;
        CharMod:   cls.op = OP_MOD;
        CharPow:   cls.op = OP_POW;
        default:   cls.op = OP_BAD;
      endcase
    end
  end

  assign full_o      = (cnt_q == 2'(QueueDepth));
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = fifo_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = req_take_i && req_valid_o;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) fifo_q[wr_ptr_q] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule

// ===== hdl/pse_back.sv =====
// ----------------------------------------------------------------------------
// pse_back
// Operand stack, arithmetic sequencer and result register.
// ----------------------------------------------------------------------------
module pse_back #(
  parameter int unsigned StackDepth = pse_pkg::StackDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_take_o,
  input  pse_pkg::req_t      req_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic signed [31:0] value_o,
  output logic [2:0]         status_o
);
  import pse_pkg::*;

  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned CW = $clog2(StackDepth + 1);

  logic [31:0]   mem [StackDepth];
  logic [31:0]   rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  status_e       err_q, err_d;
  req_t          req_q, req_d;
  logic [31:0]   r_q, r_d, l_q, l_d, top_q, top_d;
  logic [31:0]   acc_q, acc_d, sq_q, sq_d;
  logic [31:0]   rem_q, rem_d, quo_q, quo_d, div_q, div_d;
  logic [5:0]    it_q, it_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_val_q, out_val_d;
  status_e       out_st_q, out_st_d;
  logic [32:0]   trial;
  logic          ln, rn;

  // stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  assign ln      = l_q[31];
  assign rn      = r_q[31];
  assign trial   = {rem_q, quo_q[31]} - {1'b0, div_q};
  assign empty_o = !out_valid_q;
  assign value_o = out_val_q;
  assign status_o = out_st_q;

  // sequencer
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; err_d = err_q; req_d = req_q;
    r_d = r_q; l_d = l_q; top_d = top_q; acc_d = acc_q; sq_d = sq_q;
    rem_d = rem_q; quo_d = quo_q; div_d = div_q; it_d = it_q;
    out_valid_d = out_valid_q; out_val_d = out_val_q; out_st_d = out_st_q;
    req_take_o = 1'b0; rd_en = 1'b0; rd_addr = '0;
    wr_en = 1'b0; wr_addr = '0; wr_data = top_q;
    if (pop_i && out_valid_q) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_take_o = 1'b1;
          req_d = req_i;
          if (err_q != ST_OK) begin
            state_d = S_RESULT;
          end else if (req_i.op == OP_DIGIT) begin
            if (cnt_q >= CW'(StackDepth)) begin
              err_d = ST_OVERFLOW;
            end else begin
              wr_en = 1'b1;
              wr_addr = AW'(cnt_q);
              wr_data = {28'd0, req_i.digit};
              top_d = {28'd0, req_i.digit};
              cnt_d = cnt_q + CW'(1);
            end
            state_d = S_RESULT;
          end else if (req_i.op == OP_BAD) begin
            err_d = ST_INVALID;
            state_d = S_RESULT;
          end else if (cnt_q < CW'(2)) begin
            err_d = ST_UNDERFLOW;
            state_d = S_RESULT;
          end else begin
            // top is held in top_q, fetch the next entry
            rd_en = 1'b1;
            rd_addr = AW'(cnt_q - CW'(2));
            r_d = top_q;
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        l_d = rd_data_q;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_WRITE;
        case (req_q.op)
          OP_ADD: top_d = l_q + r_q;
          OP_SUB: top_d = l_q - r_q;
          OP_MUL: begin
            top_d = l_q * r_q;
          end
          OP_DIV, OP_MOD: begin
            if (r_q == 32'd0) begin
              err_d = ST_DIVZERO;
              state_d = S_RESULT;
            end else begin
              rem_d = 32'd0;
              quo_d = ln ? (32'd0 - l_q) : l_q;
              div_d = rn ? (32'd0 - r_q) : r_q;
              it_d = 6'd32;
              state_d = S_DIV;
            end
          end
          OP_POW: begin
            if (r_q[31]) begin
              if (l_q == 32'd1) top_d = 32'd1;
              else if (l_q == 32'hFFFF_FFFF) top_d = r_q[0] ? 32'hFFFF_FFFF : 32'd1;
              else top_d = 32'd0;
            end else begin
              acc_d = 32'd1;
              sq_d = l_q;
              state_d = S_POW;
            end
          end
          default: state_d = S_RESULT;
        endcase
      end
      S_DIV: begin
        // one restoring step per cycle
        if (!trial[32]) begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = {rem_q[30:0], quo_q[31]};
          quo_d = {quo_q[30:0], 1'b0};
        end
        it_d = it_q - 6'd1;
        if (it_q == 6'd1) begin
          if (req_q.op == OP_DIV) top_d = (ln != rn) ? (32'd0 - quo_d) : quo_d;
          else top_d = ln ? (32'd0 - rem_d) : rem_d;
          state_d = S_WRITE;
        end
      end
      S_POW: begin
        // square and multiply, one exponent bit per cycle
        if (r_q == 32'd0) begin
          top_d = acc_q;
          state_d = S_WRITE;
        end else begin
          if (r_q[0]) acc_d = acc_q * sq_q;
          sq_d = sq_q * sq_q;
          r_d = r_q >> 1;
        end
      end
      S_WRITE: begin
        wr_en = 1'b1;
        wr_addr = AW'(cnt_q - CW'(2));
        wr_data = top_q;
        cnt_d = cnt_q - CW'(1);
        state_d = S_RESULT;
      end
      S_RESULT: begin
        state_d = S_IDLE;
        if (req_q.last) begin
          if (out_valid_q && !pop_i) begin
            state_d = S_RESULT;
          end else begin
            out_valid_d = 1'b1;
            if (err_q != ST_OK) begin
              out_st_d = err_q; out_val_d = 32'd0;
            end else if (cnt_q == CW'(0)) begin
              out_st_d = ST_UNDERFLOW; out_val_d = 32'd0;
            end else begin
              out_st_d = ST_OK; out_val_d = top_q;
            end
            cnt_d = '0;
            err_d = ST_OK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d; r_q <= r_d; l_q <= l_d; top_q <= top_d;
    acc_q <= acc_d; sq_q <= sq_d; rem_q <= rem_d; quo_q <= quo_d;
    div_q <= div_d; it_q <= it_d; out_val_q <= out_val_d; out_st_q <= out_st_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      err_q <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      err_q <= err_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

// ===== hdl/postfix_stack_evaluator.sv =====
// Back end steps: a digit or invalid character goes from idle straight to result;
// + - * pass fetch, exec, write and result; / and % add a divide step (one quotient
// bit per cycle), a zero divisor ends at exec, ^ adds a power step unless negative.
// A two-entry queue lets characters be taken while the back end works; a waiting result
// holds the back end in the result step of the next last character until it is popped.
// Reset clears the stack count, error and result valid; stack memory is not cleared.
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Top level: character front end and stack execution back end.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
  parameter int unsigned StackDepth = pse_pkg::StackDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         symbol_i,
  input  logic               last_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] value_o,
  output logic [2:0]         status_o
);
  import pse_pkg::*;

  req_t req;
  logic req_valid, req_take;

  // front end
  pse_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .symbol_i, .last_i,
    .req_valid_o(req_valid), .req_take_i(req_take), .req_o(req)
  );

  // back end
  pse_back #(.StackDepth(StackDepth)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_take_o(req_take),
    .req_i(req), .empty_o(empty), .pop_i(pop), .value_o, .status_o
  );
endmodule

// ===== hdl/pse_checker.sv =====
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks for the postfix stack evaluator.
// ----------------------------------------------------------------------------
module pse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] value_o,
  input logic [2:0]  status_o
);
  import pse_pkg::*;

  // status codes stay in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o <= ST_OVERFLOW)) else $error("bad status");
  // error results carry zero value
  a_errval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_OK) |-> (value_o == 32'd0)) else $error("nonzero value");
  // a held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(value_o) && $stable(status_o)))
    else $error("result changed");
endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);
